### src/ewvr_pkg.sv
// Shared types and constants for the edge wheel volume router.
package ewvr_pkg;

    localparam logic [15:0] TYPE_REL      = 16'd2;
    localparam logic [15:0] CODE_WHEEL    = 16'd8;
    localparam logic [15:0] CODE_WHEEL_HI = 16'd11;

    localparam logic [15:0] WHEEL_UNITS   = 16'd120;
    // floor((2^16 - 1) / 15); quotient of (x >> 3) / 15 is low by at most one
    localparam logic [25:0] RECIP_15      = 26'd4369;

    localparam logic        ACT_FWD       = 1'b0;
    localparam logic        ACT_VOL       = 1'b1;

    localparam int          QDEPTH        = 2;
    localparam int          QPTR_W        = $clog2(QDEPTH);
    localparam int          QCNT_W        = QPTR_W + 1;

    typedef enum logic [1:0] {
        OP_FWD,
        OP_HI_AWAY,
        OP_HI_EDGE,
        OP_STD_EDGE
    } op_t;

    typedef struct packed {
        op_t                op;
        logic        [15:0] ev_type;
        logic        [15:0] ev_code;
        logic signed [15:0] ev_value;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic               action;
        logic        [15:0] out_type;
        logic        [15:0] out_code;
        logic signed [15:0] out_value;
        logic signed [15:0] volume_steps;
    } res_t;

endpackage

### src/ewvr_front.sv
// Front end: accepts beats, tracks cursor and edge, classifies events.
module ewvr_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_cmd,
    input  logic         [15:0] s_ev_type,
    input  logic         [15:0] s_ev_code,
    input  logic signed  [15:0] s_ev_value,
    input  logic signed  [15:0] s_cursor_pos,
    input  logic signed  [15:0] s_edge_pos,
    input  ewvr_pkg::q_stat_t   q_stat,
    output logic                push,
    output ewvr_pkg::item_t     push_item
);
    import ewvr_pkg::*;

    logic               hi_res_reg;
    logic               have_cursor_reg;
    logic signed [15:0] cursor_x_reg;
    logic signed [15:0] edge_x_reg;

    logic at_edge;
    logic is_hi;
    logic is_std;
    logic drop;
    logic accept;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;
    assign at_edge = have_cursor_reg && (cursor_x_reg == edge_x_reg);
    assign is_hi   = (s_ev_type == TYPE_REL) && (s_ev_code == CODE_WHEEL_HI) && hi_res_reg;
    assign is_std  = (s_ev_type == TYPE_REL) && (s_ev_code == CODE_WHEEL);

    always_comb begin
        push_item.ev_type  = s_ev_type;
        push_item.ev_code  = s_ev_code;
        push_item.ev_value = s_ev_value;
        push_item.op       = OP_FWD;
        drop               = 1'b0;
        if (is_hi) begin
            push_item.op = at_edge ? OP_HI_EDGE : OP_HI_AWAY;
        end else if (is_std && at_edge) begin
            push_item.op = OP_STD_EDGE;
            drop         = hi_res_reg;
        end
    end

    assign push = accept && !s_cmd && !drop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hi_res_reg      <= 1'b0;
            have_cursor_reg <= 1'b0;
            cursor_x_reg    <= '0;
            edge_x_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                hi_res_reg <= cfg_wr_data;
            end
            if (accept && s_cmd) begin
                have_cursor_reg <= 1'b1;
                cursor_x_reg    <= s_cursor_pos;
                edge_x_reg      <= s_edge_pos;
            end
        end
    end

endmodule

### src/ewvr_queue.sv
// Short FIFO of classified events between front and back ends.
module ewvr_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  ewvr_pkg::item_t     push_item,
    input  logic                pop,
    output ewvr_pkg::item_t     head,
    output ewvr_pkg::q_stat_t   q_stat
);
    import ewvr_pkg::*;

    item_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  cnt_reg;
    logic [QCNT_W-1:0]  cnt_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        r = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    assign head         = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign q_stat.empty = (cnt_reg == '0);

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

### src/ewvr_back.sv
// Back end: wheel remainder, step division and the result register.
module ewvr_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  ewvr_pkg::item_t     head,
    input  ewvr_pkg::q_stat_t   q_stat,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output ewvr_pkg::res_t      res
);
    import ewvr_pkg::*;

    logic signed [7:0]  rem_reg;
    logic signed [7:0]  rem_next;
    logic               m_valid_reg;
    res_t               res_reg;

    logic signed [16:0] sum;
    logic               neg;
    logic        [16:0] mag17;
    logic        [15:0] mag;
    logic        [25:0] prod;
    logic        [15:0] q0;
    logic        [15:0] r0;
    logic        [15:0] q;
    logic        [15:0] r;
    logic        [15:0] hi_steps;

    logic               emit;
    res_t               res_new;

    assign pop = !q_stat.empty && (!m_valid_reg || m_ready);

    // sum / 120 truncated toward zero, on the magnitude
    always_comb begin
        sum   = 17'(rem_reg) + 17'(head.ev_value);
        neg   = sum[16];
        mag17 = neg ? 17'(-sum) : 17'(sum);
        mag   = mag17[15:0];
        prod  = 26'(mag[15:3]) * RECIP_15;
        q0    = 16'(prod[25:16]);
        r0    = mag - 16'(q0 * WHEEL_UNITS);
        if (r0 >= WHEEL_UNITS) begin
            q = q0 + 1'b1;
            r = r0 - WHEEL_UNITS;
        end else begin
            q = q0;
            r = r0;
        end
        hi_steps = neg ? 16'(-q) : q;
    end

    always_comb begin
        rem_next             = rem_reg;
        emit                 = 1'b1;
        res_new.action       = ACT_FWD;
        res_new.out_type     = head.ev_type;
        res_new.out_code     = head.ev_code;
        res_new.out_value    = head.ev_value;
        res_new.volume_steps = '0;
        case (head.op)
            OP_FWD: begin
                emit = 1'b1;
            end
            OP_HI_AWAY: begin
                rem_next = '0;
            end
            OP_HI_EDGE: begin
                rem_next             = neg ? 8'(-r) : 8'(r);
                emit                 = (q != '0);
                res_new.action       = ACT_VOL;
                res_new.out_type     = '0;
                res_new.out_code     = '0;
                res_new.out_value    = '0;
                res_new.volume_steps = hi_steps;
            end
            OP_STD_EDGE: begin
                emit                 = (head.ev_value != '0);
                res_new.action       = ACT_VOL;
                res_new.out_type     = '0;
                res_new.out_code     = '0;
                res_new.out_value    = '0;
                res_new.volume_steps = head.ev_value;
            end
            default: begin
                emit = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                rem_reg     <= rem_next;
                m_valid_reg <= emit;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && emit) begin
            res_reg <= res_new;
        end
    end

    assign m_valid = m_valid_reg;
    assign res     = res_reg;

endmodule

### src/edge_wheel_volume_router.sv
// Top level of the edge wheel volume router.
// Usage:
//   Input channel s_*: one beat is either an input event (s_cmd = 0) or a
//   cursor update (s_cmd = 1) carrying cursor and edge x positions.
//   Result channel m_*: a forwarded event (m_action = 0) or a signed volume
//   step count (m_action = 1). Each input beat gives zero or one result.
//   cfg_wr_en/cfg_wr_data write the high-resolution wheel flag; write it
//   only while no beats are in flight.
// Timing:
//   A result passes through the queue and the result register before it
//   shows on m_valid. Throughput is one beat per cycle while m_ready is high;
//   the back end's wheel remainder and divide by 120 are combinational.
//   A two-entry queue separates the classifier from the back end, so the
//   input side keeps taking beats while a result waits on m_ready; when
//   the receiver stalls long enough the queue fills and s_ready drops.
// Reset:
//   aresetn low clears the flag, cursor state, remainder, queue and
//   result valid; s_ready is high in the first cycle after reset.
module edge_wheel_volume_router (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_cmd,
    input  logic         [15:0] s_ev_type,
    input  logic         [15:0] s_ev_code,
    input  logic signed  [15:0] s_ev_value,
    input  logic signed  [15:0] s_cursor_pos,
    input  logic signed  [15:0] s_edge_pos,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_action,
    output logic         [15:0] m_out_type,
    output logic         [15:0] m_out_code,
    output logic signed  [15:0] m_out_value,
    output logic signed  [15:0] m_volume_steps
);
    import ewvr_pkg::*;

    logic    push;
    item_t   push_item;
    logic    pop;
    item_t   head;
    q_stat_t q_stat;
    res_t    res;

    ewvr_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_ev_type    (s_ev_type),
        .s_ev_code    (s_ev_code),
        .s_ev_value   (s_ev_value),
        .s_cursor_pos (s_cursor_pos),
        .s_edge_pos   (s_edge_pos),
        .q_stat       (q_stat),
        .push         (push),
        .push_item    (push_item)
    );

    ewvr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    ewvr_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .q_stat  (q_stat),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .res     (res)
    );

    assign m_action       = res.action;
    assign m_out_type     = res.out_type;
    assign m_out_code     = res.out_code;
    assign m_out_value    = res.out_value;
    assign m_volume_steps = res.volume_steps;

`ifndef SYNTHESIS
    a_vol_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_action == ACT_VOL) |->
            (m_out_type == '0) && (m_out_code == '0) && (m_out_value == '0))
        else $error("volume beat carries event fields");

    a_vol_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_action == ACT_VOL) |-> (m_volume_steps != '0))
        else $error("volume beat with zero steps");

    a_fwd_no_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_action == ACT_FWD) |-> (m_volume_steps == '0))
        else $error("forwarded beat carries volume steps");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.full |-> !push)
        else $error("push into full queue");
`endif

endmodule
